@@ rtl/key_value_frame_parser_core_assert.svh @@
// ----------------------------------------------------------------------------
// Key/value frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_FRAME_PARSER_CORE_ASSERT_SVH
`define KEY_VALUE_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define KVFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kvfp assertion failed");

// next-cycle implication
`define KVFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kvfp assertion failed");

`endif

@@ rtl/kvfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Key/value frame parser package
// Codes, character constants and shared types.
// ----------------------------------------------------------------------------
package kvfp_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 128;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_STR   = 8'h63;
  localparam logic [7:0] CHAR_FLT   = 8'h66;
  localparam logic [7:0] CHAR_INT   = 8'h69;
  localparam logic [7:0] CHAR_BOOL  = 8'h62;
  localparam logic [7:0] CHAR_END   = 8'h3E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // first byte index that is parsed as key/value content
  localparam int unsigned BODY_START = 8;
  localparam int unsigned MIN_FRAME  = 10;

  typedef enum logic [2:0] {
    EVT_IGNORED = 3'd0,
    EVT_KEY     = 3'd1,
    EVT_SEP     = 3'd2,
    EVT_TYPE    = 3'd3,
    EVT_LEN     = 3'd4,
    EVT_VALUE   = 3'd5
  } evt_kind_e;

  typedef enum logic [2:0] {
    VT_NONE   = 3'd0,
    VT_STRING = 3'd1,
    VT_FLOAT  = 3'd2,
    VT_INT    = 3'd3,
    VT_BOOL   = 3'd4
  } val_type_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_BAD_END   = 3'd2,
    ST_SHORT     = 3'd3,
    ST_BAD_SIZE  = 3'd4,
    ST_BAD_SUM   = 3'd5
  } frame_status_e;

  typedef enum logic [4:0] {
    MODE_KEY   = 5'b00001,
    MODE_TYPE  = 5'b00010,
    MODE_LEN0  = 5'b00100,
    MODE_LEN1  = 5'b01000,
    MODE_VALUE = 5'b10000
  } parse_mode_e;

  function automatic logic [7:0] header_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = 8'h3C;
      2'd1:    c = 8'h6D;
      2'd2:    c = 8'h73;
      default: c = 8'h67;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

@@ rtl/kvfp_in_if.sv @@
// ----------------------------------------------------------------------------
// Key/value frame parser input channel
// Valid/ready channel carrying one frame byte per item.
// ----------------------------------------------------------------------------
interface kvfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

@@ rtl/kvfp_out_if.sv @@
// ----------------------------------------------------------------------------
// Key/value frame parser output channel
// Valid/ready channel carrying one classified byte event per item.
// ----------------------------------------------------------------------------
interface kvfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [2:0] value_type;
  logic [7:0] byte_out;
  logic [6:0] value_position;
  logic       pair_done;
  logic [5:0] pairs_so_far;
  logic       frame_end;
  logic [2:0] frame_status;

  modport source (
    output valid, output event_kind, output value_type, output byte_out,
    output value_position, output pair_done, output pairs_so_far,
    output frame_end, output frame_status, input ready
  );
  modport sink (
    input valid, input event_kind, input value_type, input byte_out,
    input value_position, input pair_done, input pairs_so_far,
    input frame_end, input frame_status, output ready
  );
endinterface

@@ rtl/key_value_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// Key/value frame parser core
// One byte in, one classified event out per cycle while the output register is
// not stalled. Frame bytes 0..7 form the header ("<msg", two-digit size); from
// byte 8 on, bytes are classified as key characters, ':' separators, type
// codes, string length bytes or payload bytes. The frame_last byte carries the
// frame status (header, end marker, minimum length, declared size, mod-256
// checksum) and clears the frame state. Throughput is one byte per cycle when
// the output is not stalled: each byte is classified combinationally against
// the frame state registers and lands in the output register, which accepts a
// new byte whenever it is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module key_value_frame_parser_core #(
  parameter int unsigned MAX_FRAME_BYTES = kvfp_pkg::MAX_FRAME_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kvfp_in_if.sink           in_chan_i,
  kvfp_out_if.source        out_chan_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_BYTES);

  // frame state
  logic [CntW-1:0]       byte_count_q, byte_count_d;
  logic [7:0]            running_sum_q, running_sum_d;
  logic [7:0]            previous_byte_q, previous_byte_d;
  logic                  header_ok_q, header_ok_d;
  logic [6:0]            declared_size_q, declared_size_d;
  kvfp_pkg::parse_mode_e parse_mode_q, parse_mode_d;
  kvfp_pkg::val_type_e   current_type_q, current_type_d;
  logic [15:0]           payload_remaining_q, payload_remaining_d;
  logic [6:0]            payload_index_q, payload_index_d;
  logic [7:0]            length_low_q, length_low_d;
  logic [5:0]            pair_total_q, pair_total_d;

  // output register
  logic                      out_valid_q;
  kvfp_pkg::evt_kind_e       kind_q, kind_d;
  kvfp_pkg::val_type_e       vtype_q, vtype_d;
  logic [7:0]                byte_q;
  logic [6:0]                vpos_q, vpos_d;
  logic                      done_q, done_d;
  logic [5:0]                pairs_q;
  logic                      end_q;
  kvfp_pkg::frame_status_e   status_q, status_d;

  logic       in_fire;
  logic [7:0] b;
  logic       last;
  logic [7:0] total;
  logic [7:0] sum_wo;
  logic [15:0] remain_dec;

  assign in_chan_i.ready = !out_valid_q || out_chan_o.ready;
  assign in_fire         = in_chan_i.valid && in_chan_i.ready;
  assign b               = in_chan_i.data_byte;
  assign last            = in_chan_i.frame_last;
  assign total           = running_sum_q + b;
  assign sum_wo          = total - previous_byte_q;
  assign remain_dec      = (payload_remaining_q != 16'd0) ? payload_remaining_q - 16'd1
                                                          : 16'd0;

  always_comb begin
    byte_count_d        = byte_count_q;
    running_sum_d       = running_sum_q;
    previous_byte_d     = previous_byte_q;
    header_ok_d         = header_ok_q;
    declared_size_d     = declared_size_q;
    parse_mode_d        = parse_mode_q;
    current_type_d      = current_type_q;
    payload_remaining_d = payload_remaining_q;
    payload_index_d     = payload_index_q;
    length_low_d        = length_low_q;
    pair_total_d        = pair_total_q;
    kind_d              = kvfp_pkg::EVT_IGNORED;
    vtype_d             = kvfp_pkg::VT_NONE;
    vpos_d              = 7'd0;
    done_d              = 1'b0;
    status_d            = kvfp_pkg::ST_OK;

    if (byte_count_q < CntW'(4) && b != kvfp_pkg::header_char(byte_count_q[1:0])) begin
      header_ok_d = 1'b0;
    end
    if (byte_count_q == CntW'(5)) begin
      if (kvfp_pkg::is_digit(previous_byte_q) && kvfp_pkg::is_digit(b)) begin
        declared_size_d = 7'(previous_byte_q[3:0]) * 7'd10 + 7'(b[3:0]);
      end else begin
        declared_size_d = 7'd0;
      end
    end

    if (byte_count_q >= CntW'(kvfp_pkg::BODY_START)) begin
      unique case (parse_mode_q)
        kvfp_pkg::MODE_KEY: begin
          if (b == kvfp_pkg::CHAR_COLON) begin
            kind_d       = kvfp_pkg::EVT_SEP;
            parse_mode_d = kvfp_pkg::MODE_TYPE;
          end else begin
            kind_d = kvfp_pkg::EVT_KEY;
          end
        end
        kvfp_pkg::MODE_TYPE: begin
          vtype_d = current_type_q;
          priority if (b == kvfp_pkg::CHAR_COLON) begin
            kind_d = kvfp_pkg::EVT_SEP;
          end else if (b == kvfp_pkg::CHAR_STR) begin
            kind_d         = kvfp_pkg::EVT_TYPE;
            current_type_d = kvfp_pkg::VT_STRING;
            vtype_d        = kvfp_pkg::VT_STRING;
            parse_mode_d   = kvfp_pkg::MODE_LEN0;
          end else if (b == kvfp_pkg::CHAR_FLT || b == kvfp_pkg::CHAR_INT ||
                       b == kvfp_pkg::CHAR_BOOL) begin
            kind_d = kvfp_pkg::EVT_TYPE;
            priority if (b == kvfp_pkg::CHAR_FLT) begin
              current_type_d = kvfp_pkg::VT_FLOAT;
            end else if (b == kvfp_pkg::CHAR_INT) begin
              current_type_d = kvfp_pkg::VT_INT;
            end else begin
              current_type_d = kvfp_pkg::VT_BOOL;
            end
            vtype_d             = current_type_d;
            payload_remaining_d = (b == kvfp_pkg::CHAR_BOOL) ? 16'd1 : 16'd4;
            payload_index_d     = 7'd0;
            parse_mode_d        = kvfp_pkg::MODE_VALUE;
          end else begin
            kind_d = kvfp_pkg::EVT_IGNORED;
          end
        end
        kvfp_pkg::MODE_LEN0: begin
          kind_d       = kvfp_pkg::EVT_LEN;
          vtype_d      = current_type_q;
          length_low_d = b;
          parse_mode_d = kvfp_pkg::MODE_LEN1;
        end
        kvfp_pkg::MODE_LEN1: begin
          kind_d  = kvfp_pkg::EVT_LEN;
          vtype_d = current_type_q;
          if (b[7] || (length_low_q | b) == 8'd0) begin
            done_d              = 1'b1;
            parse_mode_d        = kvfp_pkg::MODE_KEY;
            current_type_d      = kvfp_pkg::VT_NONE;
            payload_remaining_d = 16'd0;
            payload_index_d     = 7'd0;
          end else begin
            payload_remaining_d = {b, length_low_q};
            payload_index_d     = 7'd0;
            parse_mode_d        = kvfp_pkg::MODE_VALUE;
          end
        end
        default: begin
          kind_d  = kvfp_pkg::EVT_VALUE;
          vtype_d = current_type_q;
          vpos_d  = payload_index_q;
          payload_index_d     = (payload_index_q != 7'd127) ? payload_index_q + 7'd1
                                                            : payload_index_q;
          payload_remaining_d = remain_dec;
          if (remain_dec == 16'd0) begin
            done_d              = 1'b1;
            parse_mode_d        = kvfp_pkg::MODE_KEY;
            current_type_d      = kvfp_pkg::VT_NONE;
            payload_index_d     = 7'd0;
          end
        end
      endcase
    end

    if (done_d && pair_total_q != 6'd63) begin
      pair_total_d = pair_total_q + 6'd1;
    end

    if (last) begin
      priority if (!header_ok_d || byte_count_q < CntW'(3)) begin
        status_d = kvfp_pkg::ST_BAD_START;
      end else if (b != kvfp_pkg::CHAR_END) begin
        status_d = kvfp_pkg::ST_BAD_END;
      end else if (byte_count_q < CntW'(kvfp_pkg::MIN_FRAME - 1)) begin
        status_d = kvfp_pkg::ST_SHORT;
      end else if (byte_count_q >= CntMax ||
                   {1'b0, byte_count_q} != (CntW + 1)'(declared_size_d)) begin
        status_d = kvfp_pkg::ST_BAD_SIZE;
      end else if (sum_wo != previous_byte_q) begin
        status_d = kvfp_pkg::ST_BAD_SUM;
      end else begin
        status_d = kvfp_pkg::ST_OK;
      end
    end else begin
      running_sum_d   = total;
      previous_byte_d = b;
      if (byte_count_q < CntMax) begin
        byte_count_d = byte_count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q        <= '0;
      running_sum_q       <= '0;
      previous_byte_q     <= '0;
      header_ok_q         <= 1'b1;
      declared_size_q     <= '0;
      parse_mode_q        <= kvfp_pkg::MODE_KEY;
      current_type_q      <= kvfp_pkg::VT_NONE;
      payload_remaining_q <= '0;
      payload_index_q     <= '0;
      length_low_q        <= '0;
      pair_total_q        <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (in_fire) begin
        if (last) begin
          byte_count_q        <= '0;
          running_sum_q       <= '0;
          previous_byte_q     <= '0;
          header_ok_q         <= 1'b1;
          declared_size_q     <= '0;
          parse_mode_q        <= kvfp_pkg::MODE_KEY;
          current_type_q      <= kvfp_pkg::VT_NONE;
          payload_remaining_q <= '0;
          payload_index_q     <= '0;
          length_low_q        <= '0;
          pair_total_q        <= '0;
        end else begin
          byte_count_q        <= byte_count_d;
          running_sum_q       <= running_sum_d;
          previous_byte_q     <= previous_byte_d;
          header_ok_q         <= header_ok_d;
          declared_size_q     <= declared_size_d;
          parse_mode_q        <= parse_mode_d;
          current_type_q      <= current_type_d;
          payload_remaining_q <= payload_remaining_d;
          payload_index_q     <= payload_index_d;
          length_low_q        <= length_low_d;
          pair_total_q        <= pair_total_d;
        end
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= kind_d;
      vtype_q  <= vtype_d;
      byte_q   <= b;
      vpos_q   <= vpos_d;
      done_q   <= done_d;
      pairs_q  <= pair_total_d;
      end_q    <= last;
      status_q <= status_d;
    end
  end

  assign out_chan_o.valid          = out_valid_q;
  assign out_chan_o.event_kind     = kind_q;
  assign out_chan_o.value_type     = vtype_q;
  assign out_chan_o.byte_out       = byte_q;
  assign out_chan_o.value_position = vpos_q;
  assign out_chan_o.pair_done      = done_q;
  assign out_chan_o.pairs_so_far   = pairs_q;
  assign out_chan_o.frame_end      = end_q;
  assign out_chan_o.frame_status   = status_q;

`include "key_value_frame_parser_core_assert.svh"

  `KVFP_ASSERT_NOW(a_status_only_at_end,
    out_valid_q && !end_q, status_q == kvfp_pkg::ST_OK)
  `KVFP_ASSERT_NEXT(a_frame_clears,
    in_fire && last, byte_count_q == '0 && pair_total_q == '0 && header_ok_q)
  `KVFP_ASSERT_NOW(a_payload_has_type,
    out_valid_q && (kind_q == kvfp_pkg::EVT_LEN || kind_q == kvfp_pkg::EVT_VALUE),
    vtype_q != kvfp_pkg::VT_NONE)

endmodule
